FILE: hdl/tfhd_pkg.sv
// ----------------------------------------------------------------------------
// Table file header detector package
// Shared widths, constants, status codes and the types that pass between
// the front end, the item queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tfhd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 48;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned HLEN_W   = 16;
  localparam int unsigned RCNT_W   = 20;
  localparam int unsigned PROD_W   = RCNT_W + HLEN_W;
  localparam int unsigned RECENT_W = 32;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [LEN_W-1:0]    SHORT_BLOCK_LEN = 32'd128;
  localparam logic [BYTE_W-1:0]   VERSION_F5      = 8'hF5;
  localparam logic [BYTE_W-1:0]   VERSION_30      = 8'h30;
  localparam logic [BYTE_W-1:0]   HEADER_TERM     = 8'h0D;
  localparam logic [BYTE_W-1:0]   END_MARK        = 8'h1A;
  localparam logic [RECENT_W-1:0] RCNT_LIMIT      = 32'h000F_FFFF;
  localparam logic [RECENT_W-1:0] RESERVED_MASK   = 32'hFFFF_FEFE;
  localparam logic [HLEN_W-1:0]   HLEN_MIN        = 16'd32;
  localparam logic [HLEN_W-1:0]   HLEN_FOLD       = 16'd263;
  localparam logic [HLEN_W-1:0]   RLEN_MIN        = 16'd8;
  localparam logic [HLEN_W-1:0]   RLEN_MAX        = 16'd4000;
  localparam logic [POS_W-1:0]    HDR_SCAN_MAX    = 48'd68;

  localparam logic [STAT_W-1:0] ST_NONE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_HEADER   = 3'd1;
  localparam logic [STAT_W-1:0] ST_SPAN     = 3'd2;
  localparam logic [STAT_W-1:0] ST_END      = 3'd3;
  localparam logic [STAT_W-1:0] ST_DISABLED = 3'd4;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_SPAN   = 2'd2;
  localparam logic [1:0] PH_END    = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              disabled;
    logic              restart;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

FILE: hdl/tfhd_front.sv
// ----------------------------------------------------------------------------
// Table file header detector front end
// Accepts input items, tracks the stream offset across blocks and tags
// each item with its offset and whether the block is a short first block.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhd_front import tfhd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic [POS_W-1:0]  block_pos_i,
  input  wire logic [LEN_W-1:0]  block_len_i,
  input  wire logic              restart_i,
  input  wire qstat_t            q_stat_i,
  output      logic              push_o,
  output      item_t             push_item_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] last_q, last_d;
  logic [POS_W-1:0] pos_b, last_b, pos_eff;
  logic             disabled;
  logic             accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign push_o     = in_valid_i;

  always_comb begin
    pos_b    = restart_i ? '0 : pos_q;
    last_b   = restart_i ? '0 : last_q;
    disabled = (block_pos_i == '0) && (block_len_i < SHORT_BLOCK_LEN);
    pos_eff  = (block_pos_i != last_b) ? block_pos_i : pos_b;
    pos_d    = pos_q;
    last_d   = last_q;
    if (accept) begin
      if (disabled) begin
        pos_d  = pos_b;
        last_d = last_b;
      end else begin
        pos_d  = pos_eff + POS_W'(1);
        last_d = block_pos_i;
      end
    end
  end

  always_comb begin
    push_item_o.data     = data_byte_i;
    push_item_o.pos      = pos_eff;
    push_item_o.disabled = disabled;
    push_item_o.restart  = restart_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      last_q <= '0;
    end else begin
      pos_q  <= pos_d;
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tfhd_queue.sv
// ----------------------------------------------------------------------------
// Table file header detector item queue
// A short first-in first-out queue of tagged items between the front end
// and the back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhd_queue import tfhd_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t push_item_i,
  input  wire logic  pop_i,
  output      item_t head_o,
  output      qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] nxt;
    if (ptr == PtrW'(Depth - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PtrW'(1);
    end
    return nxt;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tfhd_back.sv
// ----------------------------------------------------------------------------
// Table file header detector back end
// Runs the header parser on each queued item and holds the result in an
// output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhd_back import tfhd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire item_t             head_i,
  input  wire qstat_t            q_stat_i,
  output      logic              pop_o,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [STAT_W-1:0] status_o,
  output      logic [POS_W-1:0]  span_start_o,
  output      logic [POS_W-1:0]  span_end_o,
  output      logic [HLEN_W-1:0] record_size_o
);

  logic [1:0]          phase_q, phase_d, phase_b;
  logic [RECENT_W-1:0] rb_q, rb_d, rb_b, rb_n;
  logic [POS_W-1:0]    base_q, base_d;
  logic [HLEN_W-1:0]   hl_q, hl_d;
  logic [RCNT_W-1:0]   rc_q, rc_d;
  logic [HLEN_W-1:0]   rl_q, rl_d;
  logic [POS_W-1:0]    ds_q, ds_d;
  logic [POS_W-1:0]    de_q, de_d;
  logic [POS_W-1:0]    em1_q, em1_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [POS_W-1:0]    ds_pre_q, ds_pre_d;

  logic                out_valid_q;
  logic [STAT_W-1:0]   status_q, status_d;
  logic [POS_W-1:0]    span_start_q, span_start_d;
  logic [POS_W-1:0]    span_end_q, span_end_d;
  logic [HLEN_W-1:0]   record_size_q, record_size_d;

  logic [POS_W-1:0]    p;
  logic [RECENT_W-1:0] cnt_n;
  logic [HLEN_W-1:0]   hl_raw, hl_adj;
  logic [BYTE_W-1:0]   c;
  logic                start, reserved_bad, ended;

  assign pop_o = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign c     = head_i.data;

  always_comb begin
    phase_b = head_i.restart ? PH_IDLE : phase_q;
    rb_b    = head_i.restart ? '0 : rb_q;
    rb_n    = {rb_b[RECENT_W-BYTE_W-1:0], c};
    cnt_n   = {rb_n[7:0], rb_n[15:8], rb_n[23:16], rb_n[31:24]};
    hl_raw  = {c, rb_n[15:8]};
    hl_adj  = hl_raw - HLEN_FOLD;
    p       = head_i.pos - base_q;
    start   = (c[2:0] inside {3'd3, 3'd4}) || (c[7:4] == 4'd3) ||
              (c == VERSION_F5) || (c == VERSION_30);
    reserved_bad = ((rb_n & RESERVED_MASK) != '0) &&
                   ((rb_n[15:8] & 8'hFE) > 8'd1) && ((rb_n[7:0] & 8'hFE) > 8'd1);

    phase_d = phase_q;
    rb_d    = rb_q;
    base_d  = base_q;
    hl_d    = hl_q;
    rc_d    = rc_q;
    rl_d    = rl_q;
    ds_d    = ds_q;
    de_d    = de_q;
    em1_d   = em1_q;
    ended   = 1'b0;

    if (pop_o) begin
      phase_d = phase_b;
      rb_d    = rb_b;
      if (!head_i.disabled) begin
        rb_d = rb_n;
        case (phase_b)
          PH_IDLE: begin
            if (start) begin
              phase_d = PH_HEADER;
              base_d  = head_i.pos;
              hl_d    = '0;
              rc_d    = '0;
              rl_d    = '0;
            end
          end
          PH_HEADER: begin
            if (p == POS_W'(2)) begin
              if (!(c inside {[8'd1:8'd12]})) begin
                phase_d = PH_IDLE;
              end
            end else if (p == POS_W'(3)) begin
              if (!(c inside {[8'd1:8'd31]})) begin
                phase_d = PH_IDLE;
              end
            end else if (p == POS_W'(7)) begin
              rc_d = cnt_n[RCNT_W-1:0];
              if (cnt_n == '0 || cnt_n >= RCNT_LIMIT) begin
                phase_d = PH_IDLE;
              end
            end else if (p == POS_W'(9)) begin
              hl_d = hl_raw;
              if (hl_raw <= HLEN_MIN) begin
                phase_d = PH_IDLE;
              end else if (hl_raw[4:0] == 5'd1) begin
                phase_d = phase_b;
              end else if (hl_raw > HLEN_FOLD) begin
                hl_d = hl_adj;
                if (hl_adj[4:0] != 5'd1) begin
                  phase_d = PH_IDLE;
                end
              end else begin
                phase_d = PH_IDLE;
              end
            end else if (p == POS_W'(11)) begin
              rl_d = hl_raw;
              if (hl_raw <= RLEN_MIN) begin
                phase_d = PH_IDLE;
              end
            end else if (p == POS_W'(15) && reserved_bad) begin
              phase_d = PH_IDLE;
            end else if (p == POS_W'(16) && rl_q > RLEN_MAX) begin
              phase_d = PH_IDLE;
            end else if (p > POS_W'(17) && hl_q != '0 &&
                         p == POS_W'(hl_q) - POS_W'(1)) begin
              if (c != HEADER_TERM) begin
                phase_d = PH_IDLE;
              end else begin
                ds_d    = ds_pre_q;
                em1_d   = ds_pre_q + POS_W'(prod_q);
                de_d    = ds_pre_q + POS_W'(prod_q) + POS_W'(1);
                phase_d = PH_SPAN;
              end
            end else if (p > POS_W'(hl_q) && p > HDR_SCAN_MAX) begin
              phase_d = PH_IDLE;
            end
          end
          PH_SPAN: begin
            if (head_i.pos == em1_q) begin
              if (c == END_MARK) begin
                phase_d = PH_END;
                ended   = 1'b1;
              end else begin
                phase_d = PH_IDLE;
              end
            end
          end
          default: begin
            phase_d = phase_b;
          end
        endcase
      end
    end

    prod_d   = PROD_W'(rc_d) * PROD_W'(rl_d);
    ds_pre_d = base_d + POS_W'(hl_d);
  end

  always_comb begin
    if (head_i.disabled) begin
      status_d = ST_DISABLED;
    end else begin
      case (phase_d)
        PH_IDLE:   status_d = ST_NONE;
        PH_HEADER: status_d = ST_HEADER;
        PH_SPAN:   status_d = ST_SPAN;
        PH_END:    status_d = ended ? ST_END : ST_HEADER;
        default:   status_d = ST_NONE;
      endcase
    end
    if (phase_d == PH_SPAN || phase_d == PH_END) begin
      span_start_d  = ds_d;
      span_end_d    = de_d;
      record_size_d = rl_d;
    end else begin
      span_start_d  = '0;
      span_end_d    = '0;
      record_size_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      rb_q        <= '0;
      base_q      <= '0;
      hl_q        <= '0;
      rc_q        <= '0;
      rl_q        <= '0;
      prod_q      <= '0;
      ds_pre_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      rb_q     <= rb_d;
      base_q   <= base_d;
      hl_q     <= hl_d;
      rc_q     <= rc_d;
      rl_q     <= rl_d;
      prod_q   <= prod_d;
      ds_pre_q <= ds_pre_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ds_q  <= ds_d;
    de_q  <= de_d;
    em1_q <= em1_d;
    if (pop_o) begin
      status_q      <= status_d;
      span_start_q  <= span_start_d;
      span_end_q    <= span_end_d;
      record_size_q <= record_size_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign span_start_o  = span_start_q;
  assign span_end_o    = span_end_q;
  assign record_size_o = record_size_q;

endmodule

`default_nettype wire

FILE: hdl/table_file_header_detector_top.sv
// ----------------------------------------------------------------------------
// Table file header detector
// Scans a byte stream for a table file header and reports the span of its
// record data and the end marker, one result item for every input item.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_stall_o data_byte_i, block_pos_i,
//                                             block_len_i, restart_i
//   out      output     out_valid_o/out_stall_i status_o, span_start_o,
//                                             span_end_o, record_size_o
//
// One item is taken per cycle when neither side stalls; its result is written
// first into a queue slot and then into the output register. The back end
// pops a new queued item whenever the output register is empty or its result
// is being taken. The reset is asynchronous and active low and needs no
// clearing pass. A stalled output holds its result while the queue keeps
// accepting items until it is full.
`default_nettype none

module table_file_header_detector_top import tfhd_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic [POS_W-1:0]  block_pos_i,
  input  wire logic [LEN_W-1:0]  block_len_i,
  input  wire logic              restart_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [STAT_W-1:0] status_o,
  output      logic [POS_W-1:0]  span_start_o,
  output      logic [POS_W-1:0]  span_end_o,
  output      logic [HLEN_W-1:0] record_size_o
);

  qstat_t q_stat;
  item_t  push_item, head_item;
  logic   push, pop;

  tfhd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .block_pos_i (block_pos_i),
    .block_len_i (block_len_i),
    .restart_i   (restart_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  tfhd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .stat_o      (q_stat)
  );

  tfhd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_item),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .span_start_o  (span_start_o),
    .span_end_o    (span_end_o),
    .record_size_o (record_size_o)
  );

  // An accepted item is always waiting in the queue on the next cycle.
  a_push_fills_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !q_stat.empty)
    else $error("Accepted item did not reach the queue.");

  // Without a detected header, no span is reported.
  a_none_has_no_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NONE) |->
      (span_start_o == '0 && span_end_o == '0 && record_size_o == '0))
    else $error("Span fields set without a detected header.");

  // A known span always runs past its start by at least the end marker.
  a_span_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_SPAN || status_o == ST_END)) |->
      (span_end_o != span_start_o))
    else $error("Reported span has no length.");

endmodule

`default_nettype wire

FILE: tb/table_file_header_detector_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Table file header detector testbench
// Feeds byte items into the detector, first from a short table of hand-made
// rows and some hand-picked table files, then from random table files and
// noise. A software model predicts the result item for every accepted byte;
// results are compared field by field with it or with a typed row's result.
// ----------------------------------------------------------------------------

module table_file_header_detector_top_tb;
  import tfhd_pkg::*;

  localparam int ITEM_TARGET = 1900;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_DIR     = 20;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  span_start;
    logic [POS_W-1:0]  span_end;
    logic [HLEN_W-1:0] rsize;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  bpos;
    logic [LEN_W-1:0]  blen;
    logic              restart;
    logic              typed;
    result_t           want;
  } byte_item_t;

  typedef enum int {
    FLAW_NONE, FLAW_MONTH, FLAW_DAY, FLAW_RESERVED, FLAW_TERM, FLAW_MARK
  } flaw_e;

  localparam result_t RES_NONE     = '{ST_NONE, 48'd0, 48'd0, 16'd0};
  localparam result_t RES_HEADER   = '{ST_HEADER, 48'd0, 48'd0, 16'd0};
  localparam result_t RES_DISABLED = '{ST_DISABLED, 48'd0, 48'd0, 16'd0};

  localparam byte_item_t DIR_ROWS [NUM_DIR] = '{
    '{8'h00, 48'h0, 32'h0, 1'b0, 1'b1, RES_DISABLED},
    '{8'hFF, 48'h0, 32'd127, 1'b0, 1'b1, RES_DISABLED},
    '{8'h00, 48'h0, 32'd128, 1'b0, 1'b1, RES_NONE},
    '{8'h03, 48'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, RES_HEADER},
    '{8'hFF, 48'h0, 32'd200, 1'b0, 1'b0, RES_NONE},
    '{8'h00, 48'h0, 32'd200, 1'b0, 1'b0, RES_NONE},
    '{8'hF5, 48'hFFFF_FFFF_FFFF, 32'd1, 1'b0, 1'b0, RES_NONE},
    '{8'h07, 48'hFFFF_FFFF_FFFF, 32'd1, 1'b0, 1'b0, RES_NONE},
    '{8'h0D, 48'hFFFF_FFFF_FFFF, 32'd1, 1'b0, 1'b0, RES_NONE},
    '{8'h30, 48'h0, 32'h0, 1'b1, 1'b1, RES_DISABLED},
    '{8'h34, 48'h5, 32'd4096, 1'b0, 1'b0, RES_NONE},
    '{8'h80, 48'h5, 32'h0, 1'b1, 1'b1, RES_NONE},
    '{8'h0B, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, RES_NONE},
    '{8'h3F, 48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, RES_NONE},
    '{8'h55, 48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, RES_NONE},
    '{8'hAA, 48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, RES_NONE},
    '{8'h1A, 48'h0, 32'h8000_0000, 1'b0, 1'b0, RES_NONE},
    '{8'h01, 48'h0, 32'd128, 1'b1, 1'b0, RES_NONE},
    '{8'hFE, 48'h8000_0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, RES_NONE},
    '{8'h0D, 48'h1, 32'd127, 1'b0, 1'b0, RES_NONE}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] data_byte_i = '0;
  logic [POS_W-1:0]  block_pos_i = '0;
  logic [LEN_W-1:0]  block_len_i = '0;
  logic              restart_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [POS_W-1:0]  span_start_o;
  logic [POS_W-1:0]  span_end_o;
  logic [HLEN_W-1:0] record_size_o;

  // Software copy of the detector state.
  logic [1:0]          sc_phase;
  logic [RECENT_W-1:0] sc_recent;
  logic [POS_W-1:0]    sc_pos;
  logic [POS_W-1:0]    sc_last_bp;
  logic [POS_W-1:0]    sc_origin;
  logic [RCNT_W-1:0]   sc_rcount;
  logic [HLEN_W-1:0]   sc_hlen;
  logic [HLEN_W-1:0]   sc_rlen;
  logic [POS_W-1:0]    sc_dstart;
  logic [POS_W-1:0]    sc_dend;

  result_t    awaited_results[$];
  result_t    want_r;
  int         mismatches = 0;
  int         results_seen = 0;
  int         items_sent = 0;
  int         send_pct = 0;
  int         recv_pct = 0;
  int         hold_requests = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  logic [POS_W-1:0] noise_bp = '0;
  logic [LEN_W-1:0] noise_len = 32'd4096;

  table_file_header_detector_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .block_pos_i   (block_pos_i),
    .block_len_i   (block_len_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .span_start_o  (span_start_o),
    .span_end_o    (span_end_o),
    .record_size_o (record_size_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void clear_scan();
    sc_phase   = PH_IDLE;
    sc_recent  = '0;
    sc_pos     = '0;
    sc_last_bp = '0;
    sc_origin  = '0;
    sc_rcount  = '0;
    sc_hlen    = '0;
    sc_rlen    = '0;
    sc_dstart  = '0;
    sc_dend    = '0;
  endfunction

  function automatic void header_step(input logic [7:0] c);
    logic [POS_W-1:0]    p;
    logic [RECENT_W-1:0] b;
    logic [RECENT_W-1:0] n;
    logic [31:0]         hl;
    logic [7:0]          prev;
    logic                ok;
    logic [63:0]         span;
    p = sc_pos - sc_origin + 48'd1;
    b = sc_recent;
    prev = b[15:8];
    if (p == 2) begin
      if (!(c > 0 && c < 13)) sc_phase = PH_IDLE;
    end else if (p == 3) begin
      if (!(c > 0 && c < 32)) sc_phase = PH_IDLE;
    end else if (p == 7) begin
      n = {b[7:0], b[15:8], b[23:16], b[31:24]};
      sc_rcount = n[RCNT_W-1:0];
      if (!(n > 0 && n < RCNT_LIMIT)) sc_phase = PH_IDLE;
    end else if (p == 9) begin
      hl = {16'd0, c, prev};
      ok = 1'b0;
      if (hl > HLEN_MIN) begin
        if (((hl - 32'd33) & 32'd31) == 0) begin
          ok = 1'b1;
        end else if (hl > HLEN_FOLD) begin
          hl = hl - HLEN_FOLD;
          ok = (((hl - 32'd33) & 32'd31) == 0);
        end
      end
      sc_hlen = hl[15:0];
      if (!ok) sc_phase = PH_IDLE;
    end else if (p == 11) begin
      sc_rlen = {c, prev};
      if (!(sc_rlen > RLEN_MIN)) sc_phase = PH_IDLE;
    end else if (p == 15 && (b & RESERVED_MASK) != 0 && (b[15:8] & 8'hFE) > 1 &&
                 (b[7:0] & 8'hFE) > 1) begin
      sc_phase = PH_IDLE;
    end else if (p == 16 && sc_rlen > RLEN_MAX) begin
      sc_phase = PH_IDLE;
    end else if (p > 17 && sc_hlen != 0 && p == 48'(sc_hlen) - 48'd1) begin
      if (c != HEADER_TERM) begin
        sc_phase = PH_IDLE;
      end else begin
        sc_dstart = sc_origin - 48'd1 + 48'(sc_hlen);
        span = 64'(sc_dstart) + 64'(sc_rcount) * 64'(sc_rlen) + 64'd1;
        sc_dend = span[POS_W-1:0];
        sc_phase = PH_SPAN;
      end
    end else if (p > 48'(sc_hlen) && p > HDR_SCAN_MAX) begin
      sc_phase = PH_IDLE;
    end
  endfunction

  function automatic result_t scan_byte(input byte_item_t it);
    result_t r;
    logic    ended;
    r = RES_NONE;
    ended = 1'b0;
    if (it.restart) clear_scan();
    if (it.bpos == '0 && it.blen < SHORT_BLOCK_LEN) begin
      r.status = ST_DISABLED;
    end else begin
      if (it.bpos != sc_last_bp) begin
        sc_last_bp = it.bpos;
        sc_pos = it.bpos;
      end
      sc_recent = {sc_recent[23:0], it.data};
      case (sc_phase)
        PH_IDLE: begin
          if (it.data[2:0] == 3'd3 || it.data[2:0] == 3'd4 || it.data[7:4] == 4'd3 ||
              it.data == VERSION_F5 || it.data == VERSION_30) begin
            sc_phase  = PH_HEADER;
            sc_origin = sc_pos + 48'd1;
            sc_hlen   = '0;
            sc_rcount = '0;
            sc_rlen   = '0;
          end
        end
        PH_HEADER: header_step(it.data);
        PH_SPAN: begin
          if (sc_pos == sc_dend - 48'd1) begin
            if (it.data == END_MARK) begin
              sc_phase = PH_END;
              ended = 1'b1;
            end else begin
              sc_phase = PH_IDLE;
            end
          end
        end
        default: ;
      endcase
      sc_pos = sc_pos + 48'd1;
      case (sc_phase)
        PH_IDLE:   r.status = ST_NONE;
        PH_HEADER: r.status = ST_HEADER;
        PH_SPAN:   r.status = ST_SPAN;
        default:   r.status = ended ? ST_END : ST_HEADER;
      endcase
    end
    if (sc_phase == PH_SPAN || sc_phase == PH_END) begin
      r.span_start = sc_dstart;
      r.span_end   = sc_dend;
      r.rsize      = sc_rlen;
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [POS_W-1:0] pick_block_pos();
    case ($urandom_range(9))
      0, 1, 2: return '0;
      3, 4, 5: return rand48();
      6, 7:    return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(200));
      default: return 48'($urandom_range(1, 5000));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_block_len(input logic [POS_W-1:0] bp,
                                                      input logic allow_short);
    logic [LEN_W-1:0] l;
    l = $urandom;
    if (allow_short && $urandom_range(9) == 0) l = $urandom_range(127);
    if (!allow_short && bp == '0 && l < SHORT_BLOCK_LEN) l = l + SHORT_BLOCK_LEN;
    return l;
  endfunction

  function automatic void set_idling(input int mode);
    case (mode)
      0: begin send_pct = 0;  recv_pct = 0;  end
      1: begin send_pct = 64; recv_pct = 0;  end
      2: begin send_pct = 0;  recv_pct = 64; end
      default: begin send_pct = 12; recv_pct = 12; end
    endcase
  endfunction

  task automatic offer(input byte_item_t it);
    int      gap;
    result_t pred;
    gap = 0;
    while (send_pct != 0 && $urandom_range(99) < send_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= it.data;
    block_pos_i <= it.bpos;
    block_len_i <= it.blen;
    restart_i   <= it.restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = scan_byte(it);
    awaited_results.push_back(it.typed ? it.want : pred);
    if (!(it.bpos == '0 && it.blen < SHORT_BLOCK_LEN)) items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_table_file(input logic [POS_W-1:0] bp, input int hbase,
                                 input logic fold, input logic [31:0] count,
                                 input logic [15:0] rlen, input flaw_e flaw,
                                 input logic rs);
    logic [7:0]       fb[$];
    logic [15:0]      hfield;
    logic [POS_W-1:0] cur_bp;
    logic [LEN_W-1:0] cur_len;
    longint           nrec;
    int               split_at;
    byte_item_t       it;
    hfield = 16'(hbase) + (fold ? HLEN_FOLD : 16'd0);
    case ($urandom_range(5))
      0: fb.push_back(8'h03);
      1: fb.push_back(8'h04);
      2: fb.push_back(VERSION_30);
      3: fb.push_back(VERSION_F5);
      4: fb.push_back(8'h8B);
      default: fb.push_back(8'h3C);
    endcase
    fb.push_back(8'($urandom));
    if (flaw == FLAW_MONTH) fb.push_back($urandom_range(1) ? 8'd0 : 8'($urandom_range(13, 255)));
    else fb.push_back(8'($urandom_range(1, 12)));
    if (flaw == FLAW_DAY) fb.push_back($urandom_range(1) ? 8'd0 : 8'($urandom_range(32, 255)));
    else fb.push_back(8'($urandom_range(1, 31)));
    for (int i = 0; i < 4; i++) fb.push_back(count[8*i +: 8]);
    fb.push_back(hfield[7:0]);
    fb.push_back(hfield[15:8]);
    fb.push_back(rlen[7:0]);
    fb.push_back(rlen[15:8]);
    if (flaw == FLAW_RESERVED) begin
      fb.push_back(8'($urandom));
      fb.push_back(8'($urandom));
      fb.push_back(8'($urandom) | 8'h02);
      fb.push_back(8'($urandom) | 8'h02);
    end else if ($urandom_range(1)) begin
      fb.push_back(8'($urandom));
      fb.push_back(8'($urandom));
      fb.push_back(8'($urandom_range(1)));
      fb.push_back(8'($urandom));
    end else begin
      repeat (4) fb.push_back(8'h00);
    end
    while (fb.size() < hbase - 1) fb.push_back(8'($urandom));
    fb.push_back(flaw == FLAW_TERM ? HEADER_TERM ^ 8'($urandom_range(1, 255)) : HEADER_TERM);
    nrec = longint'(count) * longint'(rlen);
    if (nrec <= 160) begin
      repeat (int'(nrec)) fb.push_back(8'($urandom));
      fb.push_back(flaw == FLAW_MARK ? END_MARK ^ 8'($urandom_range(1, 255)) : END_MARK);
      repeat ($urandom_range(4)) fb.push_back(8'($urandom));
    end else begin
      repeat (8) fb.push_back(8'($urandom));
    end
    split_at = ($urandom_range(9) < 3) ? $urandom_range(1, fb.size() - 1) : fb.size();
    cur_bp = bp;
    cur_len = pick_block_len(cur_bp, 1'b0);
    for (int i = 0; i < fb.size(); i++) begin
      if (i == split_at) begin
        cur_bp = bp + 48'(i);
        cur_len = pick_block_len(cur_bp, 1'b0);
      end
      it.data    = fb[i];
      it.bpos    = cur_bp;
      it.blen    = cur_len;
      it.restart = rs && i == 0;
      it.typed   = 1'b0;
      it.want    = RES_NONE;
      offer(it);
    end
  endtask

  task automatic send_noise(input int n);
    byte_item_t it;
    repeat (n) begin
      if ($urandom_range(99) < 15) begin
        noise_bp = pick_block_pos();
        noise_len = pick_block_len(noise_bp, 1'b1);
      end
      it.data    = 8'($urandom);
      it.bpos    = noise_bp;
      it.blen    = noise_len;
      it.restart = $urandom_range(99) < 4;
      it.typed   = 1'b0;
      it.want    = RES_NONE;
      offer(it);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result item %0d: status %0d", results_seen, status_o);
          end
        end else begin
          want_r = awaited_results.pop_front();
          if (status_o !== want_r.status || span_start_o !== want_r.span_start ||
              span_end_o !== want_r.span_end || record_size_o !== want_r.rsize) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result item %0d: expected status %0d start %h end %h size %0d",
                       results_seen, want_r.status, want_r.span_start, want_r.span_end,
                       want_r.rsize);
              $display("  got status %0d start %h end %h size %0d",
                       status_o, span_start_o, span_end_o, record_size_o);
            end
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= $urandom_range(99) < recv_pct;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          hb;
    logic [31:0] cnt;
    logic [15:0] rl;
    flaw_e       fl;
    clear_scan();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(0);
    for (int k = 0; k < NUM_DIR; k++) offer(DIR_ROWS[k]);

    send_table_file(48'h1000, 33, 1'b0, 32'd2, 16'd10, FLAW_NONE, 1'b1);
    send_table_file(48'h0, 65, 1'b1, 32'd1, 16'd9, FLAW_NONE, 1'b1);
    send_table_file(48'hFFFF_FFFF_FFF0, 33, 1'b0, 32'd3, 16'd12, FLAW_NONE, 1'b1);
    send_table_file(48'h7_0000, 97, 1'b0, 32'hFFFFE, 16'd4000, FLAW_NONE, 1'b1);
    send_table_file(48'hFFFF_FFFF_FF00, 65, 1'b0, 32'hFFFFE, 16'd4000, FLAW_NONE, 1'b1);
    send_table_file(48'h2000, 33, 1'b0, 32'd1, 16'd4001, FLAW_NONE, 1'b1);
    send_table_file(48'h3000, 33, 1'b0, 32'd2, 16'd9, FLAW_TERM, 1'b1);
    send_table_file(48'h4000, 33, 1'b0, 32'd2, 16'd9, FLAW_MARK, 1'b1);
    drain();

    hold_requests++;
    while (items_sent < ITEM_TARGET) begin
      set_idling((items_sent / 250) % 4);
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: hb = 33;
          9, 10, 11, 12, 13: hb = 65;
          14, 15, 16: hb = 97;
          default: begin
            case ($urandom_range(3))
              0: hb = 32;
              1: hb = 34;
              2: hb = 50;
              default: hb = 66;
            endcase
          end
        endcase
        if ($urandom_range(19) < 14) begin
          cnt = $urandom_range(1, 4);
        end else begin
          case ($urandom_range(4))
            0: cnt = 32'd0;
            1: cnt = 32'hFFFFF;
            2: cnt = 32'hFFFFE;
            3: cnt = 32'h100000;
            default: cnt = $urandom;
          endcase
        end
        if ($urandom_range(9) < 8) begin
          rl = 16'($urandom_range(9, 40));
        end else begin
          case ($urandom_range(5))
            0: rl = 16'd8;
            1: rl = 16'd0;
            2: rl = 16'd4000;
            3: rl = 16'd4001;
            4: rl = 16'hFFFF;
            default: rl = 16'($urandom_range(41, 4000));
          endcase
        end
        fl = ($urandom_range(3) != 0) ? FLAW_NONE : flaw_e'($urandom_range(1, 5));
        send_table_file(pick_block_pos(), hb, $urandom_range(3) == 0, cnt, rl, fl,
                        $urandom_range(99) < 85);
      end else begin
        send_noise($urandom_range(4, 24));
      end
    end

    set_idling(0);
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tfhd_pkg.sv
hdl/tfhd_front.sv
hdl/tfhd_queue.sv
hdl/tfhd_back.sv
hdl/table_file_header_detector_top.sv
tb/table_file_header_detector_top_tb.sv
